// File: hdl/avf_pkg.sv
`default_nettype none

package avf_pkg;

  // fixed widths of the data path
  localparam int DATA_W    = 32;
  localparam int COEF_W    = 18;
  localparam int EXP_W     = 15;
  localparam int ORD_W     = 4;
  localparam int KIND_W    = 2;
  localparam int LAG_W     = 3;
  localparam int LAGS      = 8;
  localparam int SEEN_W    = 4;
  localparam int SEEN_CAP  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_BITS = 16;
  localparam int COEF_FRAC = 16;
  localparam int ACC_W     = 56;
  localparam int LOG_W     = 22;
  localparam int PROD_W    = 37;
  localparam int DIV_W     = 34;
  localparam int REM_W     = 15;
  localparam int Y_W       = 36;
  localparam int IP_W      = 20;
  localparam int SH_W      = 21;
  localparam int CNT_W     = 6;

  // step counts of the iterative units
  localparam int NORM_STEPS = 5;
  localparam int LOG_STEPS  = 16;
  localparam int EXP_STEPS  = 16;
  localparam int DIV_STEPS  = DIV_W;

  // reset values
  localparam logic [EXP_W-1:0]  POW_EXP_RST = EXP_W'(16384);
  localparam logic [DATA_W-1:0] ONE_FX      = DATA_W'(1) << FRAC_BITS;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_OFFSET   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERCEPT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_EXP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_SIGMA_POW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_SHOCK_POW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ARCH_ORDER    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GARCH_ORDER   = 3'd6;

  // item kinds and coefficient tables
  localparam logic ACTION_SAMPLE = 1'b0;
  localparam logic ACTION_COEF   = 1'b1;
  localparam logic [KIND_W-1:0] KIND_PHI   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GAMMA = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BETA  = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE, OP_COEF, OP_CAPTURE, OP_BASE, OP_NORM, OP_SQUARE, OP_LOGMUL,
    OP_SCALE, OP_DIV, OP_DIVEND, OP_EXPINIT, OP_EXPSTEP, OP_EXPOUT,
    OP_MAC_ARCH, OP_MAC_GARCH, OP_SUM, OP_PUSH
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_ARCH, S_CHK, S_NORM, S_SQUARE, S_LOGMUL, S_SCALE, S_DIV,
    S_DIVEND, S_EXPINIT, S_EXPSTEP, S_EXPOUT, S_MAC_ARCH, S_MAC_GARCH,
    S_SUM, S_PUSH
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [LAG_W-1:0] lag;
    logic [CNT_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic [SEEN_W-1:0] seen;
    logic [ORD_W-1:0]  arch_cnt;
    logic [ORD_W-1:0]  garch_cnt;
    logic              m_zero;
  } stat_t;

  // 2^(2^-i) for i = 1..16 as Q1.31, each the integer root of the one before
  typedef logic [EXP_STEPS-1:0][DATA_W-1:0] roots_t;

  function automatic roots_t build_roots();
    roots_t      tab;
    logic [63:0] prev;
    logic [63:0] r;
    logic [63:0] t;
    logic [63:0] v;
    prev = 64'h1_0000_0000;
    for (int i = 0; i < EXP_STEPS; i++) begin
      v = prev << 31;
      r = 64'd0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= v) r = t;
      end
      tab[i] = r[DATA_W-1:0];
      prev = r;
    end
    return tab;
  endfunction

  localparam roots_t ROOTS = build_roots();

endpackage

`default_nettype wire

// File: hdl/avf_if.sv
`default_nettype none

// sample / coefficient channel
interface avf_in_if;
  import avf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic signed [DATA_W-1:0] sample;
  logic [KIND_W-1:0]        coef_kind;
  logic [LAG_W-1:0]         coef_index;
  logic signed [COEF_W-1:0] coef_value;
  modport source(output valid, action, sample, coef_kind, coef_index, coef_value,
                 input ready);
  modport sink(input valid, action, sample, coef_kind, coef_index, coef_value,
               output ready);
endinterface

// sigma channel
interface avf_out_if;
  import avf_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] sigma;
  logic              saturated;
  modport source(output valid, sigma, saturated, input ready);
  modport sink(input valid, sigma, saturated, output ready);
endinterface

`default_nettype wire

// File: hdl/avf_datapath.sv
`default_nettype none

module avf_datapath (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  avf_pkg::cmd_t                     cmd_i,
  output avf_pkg::stat_t                    stat_o,
  input  wire                               cfg_we_i,
  input  wire [avf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire [avf_pkg::DATA_W-1:0]         cfg_data_i,
  input  wire signed [avf_pkg::DATA_W-1:0]  sample_i,
  input  wire [avf_pkg::KIND_W-1:0]         coef_kind_i,
  input  wire [avf_pkg::LAG_W-1:0]          coef_index_i,
  input  wire signed [avf_pkg::COEF_W-1:0]  coef_value_i,
  output logic [avf_pkg::DATA_W-1:0]        sigma_o,
  output logic                              saturated_o
);
  import avf_pkg::*;

  // configuration
  logic [DATA_W-1:0] mean_q, icpt_q, pre_sig_q, pre_shk_q;
  logic [EXP_W-1:0]  pexp_q;
  logic [ORD_W-1:0]  arch_q, garch_q;

  // coefficient tables and history
  logic [COEF_W-1:0] phi_q [LAGS];
  logic [COEF_W-1:0] gam_q [LAGS];
  logic [COEF_W-1:0] beta_q [LAGS];
  logic [DATA_W-1:0] hist_e_q [LAGS];
  logic [DATA_W-1:0] hist_s_q [LAGS];
  logic [SEEN_W-1:0] seen_q;

  // working registers
  logic [DATA_W-1:0]        e_q, s_q, m_q, pow_q, sigma_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     sat_q, sat_out_q, inv_q, neg_q;
  logic [4:0]               k_q;
  logic [LOG_STEPS-1:0]     frac_q, f_q;
  logic [PROD_W-1:0]        prod_q;
  logic [DIV_W-1:0]         div_q;
  logic [REM_W-1:0]         rem_q;
  logic signed [Y_W-1:0]    y_q;
  logic signed [IP_W-1:0]   ip_q;

  // combinational results
  logic                     lag_hist;
  logic [ORD_W-1:0]         arch_cnt, garch_cnt;
  logic [EXP_W-1:0]         dexp;
  logic signed [DATA_W:0]   e_diff;
  logic [DATA_W-1:0]        e_clip;
  logic                     e_sat;
  logic signed [DATA_W-1:0] ev;
  logic [DATA_W:0]          ae;
  logic signed [49:0]       gprod;
  logic signed [50:0]       base;
  logic [DATA_W-1:0]        base_clip;
  logic                     base_sat;
  logic [COEF_W-1:0]        coef;
  logic [DATA_W-1:0]        gval;
  logic signed [50:0]       term;
  logic signed [ACC_W-1:0]  acc_sh;
  logic [DATA_W-1:0]        sum_clip;
  logic                     sum_sat;
  logic [DATA_W-1:0]        norm_m;
  logic [4:0]               norm_k;
  logic [63:0]              sq;
  logic [5:0]               ksub;
  logic signed [LOG_W-1:0]  logv;
  logic [LOG_W-1:0]         ulog;
  logic [PROD_W-1:0]        prod;
  logic [23:0]              mag;
  logic [DIV_W-1:0]         div_init;
  logic [REM_W:0]           r2;
  logic                     ge;
  logic [63:0]              emul;
  logic signed [SH_W-1:0]   shv;
  logic [SH_W-1:0]          nsh;
  logic [DATA_W-1:0]        exp_res;
  logic                     exp_sat;

  always_comb begin
    // order clamps and history check
    lag_hist  = {1'b0, cmd_i.lag} < seen_q;
    arch_cnt  = (arch_q == '0) ? ORD_W'(1) : (arch_q > ORD_W'(LAGS)) ? ORD_W'(LAGS) : arch_q;
    garch_cnt = (garch_q == '0) ? ORD_W'(1) : (garch_q > ORD_W'(LAGS)) ? ORD_W'(LAGS) : garch_q;
    dexp      = (pexp_q == '0) ? EXP_W'(1) : pexp_q;

    // demeaned shock
    e_diff = $signed({sample_i[DATA_W-1], sample_i}) - $signed({mean_q[DATA_W-1], mean_q});
    e_sat  = e_diff[DATA_W] != e_diff[DATA_W-1];
    if (!e_sat) e_clip = e_diff[DATA_W-1:0];
    else if (e_diff[DATA_W]) e_clip = {1'b1, {(DATA_W-1){1'b0}}};
    else e_clip = {1'b0, {(DATA_W-1){1'b1}}};

    // asymmetric base
    ev    = $signed(hist_e_q[cmd_i.lag]);
    ae    = ev[DATA_W-1] ? (DATA_W+1)'(-$signed({ev[DATA_W-1], ev})) : {1'b0, ev};
    gprod = $signed(gam_q[cmd_i.lag]) * ev;
    base  = $signed({18'd0, ae}) - ($signed({gprod[49], gprod}) >>> COEF_FRAC);
    base_sat = 1'b0;
    base_clip = base[DATA_W-1:0];
    if (base[50]) begin
      base_clip = '0;
      base_sat  = 1'b1;
    end else if (|base[49:DATA_W]) begin
      base_clip = '1;
      base_sat  = 1'b1;
    end

    // multiply-accumulate operand select
    if (cmd_i.op == OP_MAC_ARCH) begin
      coef = phi_q[cmd_i.lag];
      gval = lag_hist ? pow_q : pre_shk_q;
    end else begin
      coef = beta_q[cmd_i.lag];
      gval = lag_hist ? hist_s_q[cmd_i.lag] : pre_sig_q;
    end
    term = $signed(coef) * $signed({1'b0, gval});

    // recursion sum
    acc_sh  = acc_q >>> COEF_FRAC;
    sum_sat = 1'b0;
    sum_clip = acc_sh[DATA_W-1:0];
    if (acc_sh[ACC_W-1]) begin
      sum_clip = '0;
      sum_sat  = 1'b1;
    end else if (|acc_sh[ACC_W-2:DATA_W]) begin
      sum_clip = '1;
      sum_sat  = 1'b1;
    end

    // leading-one search, halving shift each step
    norm_m = m_q;
    norm_k = k_q;
    unique case (cmd_i.step[2:0])
      3'd0: if (m_q[31:16] == '0) begin norm_m = m_q << 16; norm_k = k_q - 5'd16; end
      3'd1: if (m_q[31:24] == '0) begin norm_m = m_q << 8;  norm_k = k_q - 5'd8;  end
      3'd2: if (m_q[31:28] == '0) begin norm_m = m_q << 4;  norm_k = k_q - 5'd4;  end
      3'd3: if (m_q[31:30] == '0) begin norm_m = m_q << 2;  norm_k = k_q - 5'd2;  end
      3'd4: if (!m_q[31]) begin norm_m = m_q << 1; norm_k = k_q - 5'd1; end
      default: ;
    endcase

    // log2 squaring step
    sq = 64'(m_q) * 64'(m_q);

    // log value times exponent ratio
    ksub = 6'({1'b0, k_q}) - 6'(FRAC_BITS);
    logv = $signed({ksub, frac_q});
    ulog = logv[LOG_W-1] ? LOG_W'(-logv) : LOG_W'(logv);
    if (inv_q) prod = PROD_W'({ulog, 13'd0});
    else prod = PROD_W'(ulog) * PROD_W'(dexp);

    // rounding and divider load
    mag      = 24'((prod_q + PROD_W'(4096)) >> 13);
    div_init = prod_q[DIV_W-1:0] + DIV_W'(dexp >> 1);

    // restoring divide step
    r2 = {rem_q, div_q[DIV_W-1]};
    ge = r2 >= {1'b0, dexp};

    // exp2 table multiply
    emul = 64'(m_q) * 64'(ROOTS[cmd_i.step[3:0]]);

    // final scaling of 2^frac
    shv = $signed({ip_q[IP_W-1], ip_q}) + SH_W'(FRAC_BITS) - SH_W'(31);
    nsh = SH_W'(-shv);
    exp_sat = 1'b0;
    if (!shv[SH_W-1] && shv != '0) begin
      exp_res = '1;
      exp_sat = 1'b1;
    end else if (|nsh[SH_W-1:5]) begin
      exp_res = '0;
    end else begin
      exp_res = m_q >> nsh[4:0];
    end
  end

  assign stat_o = '{seen: seen_q, arch_cnt: arch_cnt, garch_cnt: garch_cnt,
                    m_zero: (m_q == '0)};

  // configuration, tables and history count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q    <= '0;
      icpt_q    <= '0;
      pexp_q    <= POW_EXP_RST;
      pre_sig_q <= ONE_FX;
      pre_shk_q <= ONE_FX;
      arch_q    <= ORD_W'(1);
      garch_q   <= ORD_W'(1);
      seen_q    <= '0;
      for (int i = 0; i < LAGS; i++) begin
        phi_q[i]  <= '0;
        gam_q[i]  <= '0;
        beta_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MEAN_OFFSET:   mean_q    <= cfg_data_i;
          REG_INTERCEPT:     icpt_q    <= cfg_data_i;
          REG_POWER_EXP:     pexp_q    <= cfg_data_i[EXP_W-1:0];
          REG_PRE_SIGMA_POW: pre_sig_q <= cfg_data_i;
          REG_PRE_SHOCK_POW: pre_shk_q <= cfg_data_i;
          REG_ARCH_ORDER:    arch_q    <= cfg_data_i[ORD_W-1:0];
          REG_GARCH_ORDER:   garch_q   <= cfg_data_i[ORD_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.op == OP_COEF) begin
        case (coef_kind_i)
          KIND_PHI:   phi_q[coef_index_i]  <= coef_value_i;
          KIND_GAMMA: gam_q[coef_index_i]  <= coef_value_i;
          KIND_BETA:  beta_q[coef_index_i] <= coef_value_i;
          default: ;
        endcase
      end
      if (cmd_i.op == OP_PUSH && seen_q < SEEN_W'(SEEN_CAP)) seen_q <= seen_q + SEEN_W'(1);
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_CAPTURE: begin
        e_q   <= e_clip;
        sat_q <= e_sat;
        acc_q <= $signed(ACC_W'({icpt_q, 16'd0}));
        inv_q <= 1'b0;
      end
      OP_BASE: begin
        m_q    <= base_clip;
        k_q    <= 5'd31;
        frac_q <= '0;
        pow_q  <= '0;
        if (base_sat) sat_q <= 1'b1;
      end
      OP_NORM: begin
        m_q <= norm_m;
        k_q <= norm_k;
      end
      OP_SQUARE: begin
        if (sq[63]) begin
          frac_q[4'd15 - cmd_i.step[3:0]] <= 1'b1;
          m_q <= sq[63:32];
        end else begin
          m_q <= sq[62:31];
        end
      end
      OP_LOGMUL: begin
        prod_q <= prod;
        neg_q  <= logv[LOG_W-1];
      end
      OP_SCALE: begin
        if (inv_q) begin
          div_q <= div_init;
          rem_q <= '0;
        end else begin
          y_q <= neg_q ? -$signed(Y_W'(mag)) : $signed(Y_W'(mag));
        end
      end
      OP_DIV: begin
        div_q <= {div_q[DIV_W-2:0], ge};
        rem_q <= ge ? REM_W'(r2 - {1'b0, dexp}) : REM_W'(r2);
      end
      OP_DIVEND: y_q <= neg_q ? -$signed(Y_W'(div_q)) : $signed(Y_W'(div_q));
      OP_EXPINIT: begin
        ip_q <= y_q[Y_W-1:16];
        f_q  <= y_q[15:0];
        m_q  <= DATA_W'(1) << 31;
      end
      OP_EXPSTEP: if (f_q[4'd15 - cmd_i.step[3:0]]) m_q <= emul[62:31];
      OP_EXPOUT: begin
        pow_q <= exp_res;
        if (exp_sat) sat_q <= 1'b1;
      end
      OP_MAC_ARCH, OP_MAC_GARCH: acc_q <= acc_q + ACC_W'(term);
      OP_SUM: begin
        s_q    <= sum_clip;
        m_q    <= sum_clip;
        k_q    <= 5'd31;
        frac_q <= '0;
        pow_q  <= '0;
        inv_q  <= 1'b1;
        if (sum_sat) sat_q <= 1'b1;
      end
      OP_PUSH: begin
        sigma_q   <= pow_q;
        sat_out_q <= sat_q;
        hist_e_q[0] <= e_q;
        hist_s_q[0] <= s_q;
        for (int i = 1; i < LAGS; i++) begin
          hist_e_q[i] <= hist_e_q[i-1];
          hist_s_q[i] <= hist_s_q[i-1];
        end
      end
      default: ;
    endcase
  end

  assign sigma_o     = sigma_q;
  assign saturated_o = sat_out_q;

endmodule

`default_nettype wire

// File: hdl/avf_ctrl.sv
`default_nettype none

module avf_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  input  wire             in_action_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  input  avf_pkg::stat_t  stat_i,
  output avf_pkg::cmd_t   cmd_o
);
  import avf_pkg::*;

  state_e            state_q, state_d;
  logic [LAG_W-1:0]  lag_q, lag_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              inv_q, inv_d;
  logic              oval_q, oval_d;
  logic              lag_hist;
  op_e               op;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lag_q   <= '0;
      cnt_q   <= '0;
      inv_q   <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      lag_q   <= lag_d;
      cnt_q   <= cnt_d;
      inv_q   <= inv_d;
      oval_q  <= oval_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    lag_d   = lag_q;
    cnt_d   = cnt_q;
    inv_d   = inv_q;
    oval_d  = oval_q && !out_ready_i;
    op      = OP_NONE;
    in_ready_o = 1'b0;
    lag_hist = {1'b0, lag_q} < stat_i.seen;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_action_i == ACTION_COEF) begin
            op = OP_COEF;
          end else begin
            op      = OP_CAPTURE;
            lag_d   = '0;
            inv_d   = 1'b0;
            state_d = S_ARCH;
          end
        end
      end
      S_ARCH: begin
        if (lag_hist) begin
          op      = OP_BASE;
          state_d = S_CHK;
        end else begin
          state_d = S_MAC_ARCH;
        end
      end
      S_CHK: begin
        cnt_d = '0;
        if (stat_i.m_zero) state_d = inv_q ? S_PUSH : S_MAC_ARCH;
        else state_d = S_NORM;
      end
      S_NORM: begin
        op = OP_NORM;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NORM_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_SQUARE;
        end
      end
      S_SQUARE: begin
        op = OP_SQUARE;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(LOG_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_LOGMUL;
        end
      end
      S_LOGMUL: begin
        op      = OP_LOGMUL;
        state_d = S_SCALE;
      end
      S_SCALE: begin
        op      = OP_SCALE;
        cnt_d   = '0;
        state_d = inv_q ? S_DIV : S_EXPINIT;
      end
      S_DIV: begin
        op = OP_DIV;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_DIVEND;
        end
      end
      S_DIVEND: begin
        op      = OP_DIVEND;
        state_d = S_EXPINIT;
      end
      S_EXPINIT: begin
        op      = OP_EXPINIT;
        cnt_d   = '0;
        state_d = S_EXPSTEP;
      end
      S_EXPSTEP: begin
        op = OP_EXPSTEP;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(EXP_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_EXPOUT;
        end
      end
      S_EXPOUT: begin
        op      = OP_EXPOUT;
        state_d = inv_q ? S_PUSH : S_MAC_ARCH;
      end
      S_MAC_ARCH: begin
        op = OP_MAC_ARCH;
        if ({1'b0, lag_q} == stat_i.arch_cnt - ORD_W'(1)) begin
          lag_d   = '0;
          state_d = S_MAC_GARCH;
        end else begin
          lag_d   = lag_q + LAG_W'(1);
          state_d = S_ARCH;
        end
      end
      S_MAC_GARCH: begin
        op = OP_MAC_GARCH;
        if ({1'b0, lag_q} == stat_i.garch_cnt - ORD_W'(1)) begin
          lag_d   = '0;
          state_d = S_SUM;
        end else begin
          lag_d = lag_q + LAG_W'(1);
        end
      end
      S_SUM: begin
        op      = OP_SUM;
        inv_d   = 1'b1;
        state_d = S_CHK;
      end
      S_PUSH: begin
        // wait for the output register to free up
        if (!oval_q || out_ready_i) begin
          op      = OP_PUSH;
          oval_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = oval_q;
  assign cmd_o = '{op: op, lag: lag_q, step: cnt_q};

endmodule

`default_nettype wire

// File: hdl/aparch_volatility_filter_top.sv
`default_nettype none

// channel  | dir | payload                                          | words
// in_i     | in  | action, sample, coef_kind, coef_index, coef_value | sample or coef write
// out_o    | out | sigma, saturated                                 | one per sample
// cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i                  | register write
//
// A coefficient write is taken in the idle state. A sample runs, for each of the p shock
// lags that read history, the power path (skipped for a zero base), uses the presample
// value for the other lags, sums the q sigma lags and takes the root (skipped for a zero sum).
// The log2 squaring, exp2 multiplies and sigma root divider run one step a cycle.
// Reset is asynchronous and active low; the tables clear at once.
// A finished sigma waits in the output register; the next sample stalls at its push.

module aparch_volatility_filter_top (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  avf_in_if.sink                       in_i,
  avf_out_if.source                    out_o,
  input  wire                          cfg_we_i,
  input  wire [avf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [avf_pkg::DATA_W-1:0]    cfg_data_i
);
  import avf_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;
  logic  out_valid;
  logic [DATA_W-1:0] sigma;
  logic  saturated;

  // sequencer
  avf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // arithmetic and state
  avf_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .sample_i     (in_i.sample),
    .coef_kind_i  (in_i.coef_kind),
    .coef_index_i (in_i.coef_index),
    .coef_value_i (in_i.coef_value),
    .sigma_o      (sigma),
    .saturated_o  (saturated)
  );

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid;
  assign out_o.sigma     = sigma;
  assign out_o.saturated = saturated;

endmodule

`default_nettype wire

// File: dv/avf_checker.sv
`timescale 1ns / 1ps

module avf_checker
  import avf_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  avf_in_if                   in_mon,
  avf_out_if                  out_mon,
  input  wire                 cfg_we_i,
  input  wire [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [DATA_W-1:0]    cfg_data_i,
  output int                  pending_o,
  output int                  errors_o
);

  typedef struct packed {
    logic [DATA_W-1:0] sigma;
    logic              saturated;
  } vol_word_t;

  // register copies
  logic signed [DATA_W-1:0] mu;
  logic [DATA_W-1:0]        omega;
  logic [EXP_W-1:0]         delta;
  logic [DATA_W-1:0]        pre_sig_pow;
  logic [DATA_W-1:0]        pre_shock_pow;
  logic [ORD_W-1:0]         p_ord;
  logic [ORD_W-1:0]         q_ord;

  // filter state
  logic [DATA_W-1:0]        shock_hist [LAGS];
  logic [DATA_W-1:0]        spow_hist  [LAGS];
  int                       seen;
  logic signed [COEF_W-1:0] phi_tab   [LAGS];
  logic signed [COEF_W-1:0] gamma_tab [LAGS];
  logic signed [COEF_W-1:0] beta_tab  [LAGS];

  longint unsigned sqrt2_tab [17];
  vol_word_t       sigma_q [$];
  bit              step_sat;

  assign pending_o = sigma_q.size();

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  initial begin
    sqrt2_tab[0] = 64'd1 << 32;
    sqrt2_tab[1] = int_sqrt(64'd1 << 63);
    for (int i = 2; i <= 16; i++) sqrt2_tab[i] = int_sqrt(sqrt2_tab[i-1] << 31);
  end

  // a^(num/den) through truncated log2 and exp2
  function automatic logic [31:0] fx_power(input logic [31:0] a,
                                           input longint unsigned num,
                                           input longint unsigned den);
    int              k;
    longint unsigned m, ulog, mag;
    longint          logv, y, ip, sh;
    logic [15:0]     frac, f;
    bit              neg;
    if (a == 0) return 0;
    k = 31;
    while (!a[k]) k--;
    m = longint'(a) << (31 - k);
    frac = '0;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= (64'd1 << 32)) begin
        frac[i] = 1'b1;
        m = m >> 1;
      end
    end
    logv = longint'(k - FRAC_BITS) * 65536 + longint'(frac);
    neg  = logv < 0;
    ulog = neg ? -logv : logv;
    mag  = (ulog * num + den / 2) / den;
    y    = neg ? -longint'(mag) : longint'(mag);
    ip   = y >>> 16;
    f    = 16'(y - ip * 65536);
    m    = 64'd1 << 31;
    for (int i = 1; i <= 16; i++)
      if (f[16-i]) m = (m * sqrt2_tab[i]) >> 31;
    sh = ip + FRAC_BITS - 31;
    if (sh > 0) begin
      step_sat = 1'b1;
      return 32'hFFFF_FFFF;
    end
    if (-sh >= 64) return 0;
    return 32'(m >> (-sh));
  endfunction

  function automatic logic [31:0] clamp_u32(input longint v);
    if (v < 0) begin
      step_sat = 1'b1;
      return 0;
    end
    if (v > 64'sh0_FFFF_FFFF) begin
      step_sat = 1'b1;
      return 32'hFFFF_FFFF;
    end
    return 32'(v);
  endfunction

  // one return sample: sigma of this step, then history update
  function automatic vol_word_t filter_step(input logic signed [31:0] x);
    int          p, q;
    longint      acc, ev, ae, base, e;
    logic [31:0] g, sp, s, d;
    vol_word_t   w;
    step_sat = 1'b0;
    p = (p_ord < 1) ? 1 : (p_ord > LAGS ? LAGS : p_ord);
    q = (q_ord < 1) ? 1 : (q_ord > LAGS ? LAGS : q_ord);
    d = (delta == 0) ? 1 : delta;
    acc = longint'(omega) * 65536;
    for (int i = 0; i < p; i++) begin
      if (i < seen) begin
        ev   = longint'($signed(shock_hist[i]));
        ae   = ev < 0 ? -ev : ev;
        base = ae - ((longint'(gamma_tab[i]) * ev) >>> 16);
        g    = fx_power(clamp_u32(base), d, 8192);
      end else begin
        g = pre_shock_pow;
      end
      acc += longint'(phi_tab[i]) * longint'(g);
    end
    for (int i = 0; i < q; i++) begin
      sp = (i < seen) ? spow_hist[i] : pre_sig_pow;
      acc += longint'(beta_tab[i]) * longint'(sp);
    end
    s = clamp_u32(acc >>> 16);
    w.sigma = fx_power(s, 8192, d);
    e = longint'(x) - longint'(mu);
    if (e > 64'sd2147483647) begin
      e = 64'sd2147483647;
      step_sat = 1'b1;
    end
    if (e < -64'sd2147483648) begin
      e = -64'sd2147483648;
      step_sat = 1'b1;
    end
    for (int i = LAGS - 1; i > 0; i--) begin
      shock_hist[i] = shock_hist[i-1];
      spow_hist[i]  = spow_hist[i-1];
    end
    shock_hist[0] = 32'(e);
    spow_hist[0]  = s;
    if (seen < SEEN_CAP) seen++;
    w.saturated = step_sat;
    return w;
  endfunction

  // watch config, input and output words
  always @(posedge clk_i or negedge rst_ni) begin
    vol_word_t want;
    if (!rst_ni) begin
      mu = 0; omega = 0; delta = POW_EXP_RST;
      pre_sig_pow = ONE_FX; pre_shock_pow = ONE_FX;
      p_ord = ORD_W'(1); q_ord = ORD_W'(1); seen = 0;
      for (int i = 0; i < LAGS; i++) begin
        phi_tab[i] = '0; gamma_tab[i] = '0; beta_tab[i] = '0;
      end
      sigma_q.delete();
      errors_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MEAN_OFFSET:   mu = cfg_data_i;
          REG_INTERCEPT:     omega = cfg_data_i;
          REG_POWER_EXP:     delta = cfg_data_i[EXP_W-1:0];
          REG_PRE_SIGMA_POW: pre_sig_pow = cfg_data_i;
          REG_PRE_SHOCK_POW: pre_shock_pow = cfg_data_i;
          REG_ARCH_ORDER:    p_ord = cfg_data_i[ORD_W-1:0];
          REG_GARCH_ORDER:   q_ord = cfg_data_i[ORD_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (sigma_q.size() == 0) begin
          $error("sigma word with nothing expected: sigma %h", out_mon.sigma);
          errors_o++;
        end else begin
          want = sigma_q.pop_front();
          if (out_mon.sigma !== want.sigma) begin
            $error("sigma: expected %h actual %h", want.sigma, out_mon.sigma);
            errors_o++;
          end
          if (out_mon.saturated !== want.saturated) begin
            $error("saturated: expected %b actual %b", want.saturated,
                   out_mon.saturated);
            errors_o++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.action == ACTION_COEF) begin
          case (in_mon.coef_kind)
            KIND_PHI:   phi_tab[in_mon.coef_index] = in_mon.coef_value;
            KIND_GAMMA: gamma_tab[in_mon.coef_index] = in_mon.coef_value;
            KIND_BETA:  beta_tab[in_mon.coef_index] = in_mon.coef_value;
            default: ;
          endcase
        end else begin
          sigma_q.push_back(filter_step(in_mon.sample));
        end
      end
    end
  end

endmodule

// File: dv/tb_aparch_volatility_filter_top.sv
`timescale 1ns / 1ps

module tb_aparch_volatility_filter_top;
  import avf_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DATA_W-1:0]    cfg_data_i;
  int                   pending;
  int                   errors;
  bit                   gaps_on;
  bit                   stall_req;
  int                   stall_left;

  avf_in_if  in_ch ();
  avf_out_if out_ch ();

  aparch_volatility_filter_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  avf_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

  // sigma receiver: random gaps, plus a long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_req && stall_left == 0) stall_left = 3000;
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
        if (stall_left == 0) stall_req = 1'b0;
      end else begin
        out_ch.ready = !gaps_on || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  task automatic send_word(input logic act, input logic [31:0] smp,
                           input logic [KIND_W-1:0] kind, input logic [LAG_W-1:0] idx,
                           input logic [COEF_W-1:0] val);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(0, 99) < 33) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid      = 1'b1;
    in_ch.action     = act;
    in_ch.sample     = smp;
    in_ch.coef_kind  = kind;
    in_ch.coef_index = idx;
    in_ch.coef_value = val;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic send_sample(input logic [31:0] smp);
    send_word(ACTION_SAMPLE, smp, KIND_W'($urandom), LAG_W'($urandom), COEF_W'($urandom));
  endtask

  task automatic send_coef(input logic [KIND_W-1:0] kind, input logic [LAG_W-1:0] idx,
                           input logic [COEF_W-1:0] val);
    send_word(ACTION_COEF, $urandom, kind, idx, val);
  endtask

  // wait for the filter to drain before touching registers
  task automatic drain();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (500) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [31:0] pick_exponent();
    case ($urandom_range(0, 6))
      0: return 0;
      1: return 1;
      2: return 8192;
      3: return 16384;
      4: return 32767 | ($urandom & 32'hFFFF_8000);
      default: return $urandom_range(4096, 24576);
    endcase
  endfunction

  // mostly plausible coefficients, sometimes anything
  function automatic logic [COEF_W-1:0] pick_coef(input logic [KIND_W-1:0] kind);
    if ($urandom_range(0, 3) == 0) return COEF_W'($urandom);
    case (kind)
      KIND_PHI:   return COEF_W'($urandom_range(0, 16384));
      KIND_GAMMA: return 18'($signed($urandom_range(0, 65536)) - 32768);
      default:    return COEF_W'($urandom_range(0, 58982));
    endcase
  endfunction

  function automatic logic [31:0] pick_sample();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 524288)) - 262144);
  endfunction

  task automatic random_phase(input int n_items, input bit extreme);
    logic [KIND_W-1:0] kind;
    drain();
    write_reg(REG_MEAN_OFFSET, extreme ? ($urandom_range(0, 1) ? 32'h8000_0000 :
              32'h7FFF_FFFF) : 32'($signed($urandom_range(0, 32768)) - 16384));
    write_reg(REG_INTERCEPT, extreme ? $urandom : $urandom_range(0, 8192));
    write_reg(REG_POWER_EXP, pick_exponent());
    write_reg(REG_PRE_SIGMA_POW, extreme ? $urandom : $urandom_range(0, 262144));
    write_reg(REG_PRE_SHOCK_POW, extreme ? $urandom : $urandom_range(0, 262144));
    write_reg(REG_ARCH_ORDER, $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(1, 8));
    write_reg(REG_GARCH_ORDER, $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(1, 8));
    for (int n = 0; n < n_items; n++) begin
      if ($urandom_range(0, 99) < 15) begin
        kind = $urandom_range(0, 19) == 0 ? KIND_UNUSED : KIND_W'($urandom_range(0, 2));
        send_coef(kind, LAG_W'($urandom), pick_coef(kind));
      end else begin
        send_sample(pick_sample());
      end
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    in_ch.valid      = 1'b0;
    in_ch.action     = ACTION_SAMPLE;
    in_ch.sample     = '0;
    in_ch.coef_kind  = KIND_PHI;
    in_ch.coef_index = '0;
    in_ch.coef_value = '0;
    gaps_on          = 1'b1;
    stall_req        = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset config, presample lags, then coefficient extremes
    send_sample(32'h0001_0000);
    send_coef(KIND_PHI, 3'd0, 18'sh1FFFF);
    send_coef(KIND_GAMMA, 3'd0, 18'sh20000);
    send_coef(KIND_BETA, 3'd0, 18'd52429);
    send_coef(KIND_PHI, 3'd7, 18'd6554);
    send_coef(KIND_GAMMA, 3'd7, 18'sh1FFFF);
    send_coef(KIND_BETA, 3'd7, 18'sh20000);
    send_coef(KIND_UNUSED, 3'd5, 18'sh1FFFF);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    send_coef(KIND_PHI, 3'd0, 18'd13107);
    send_coef(KIND_GAMMA, 3'd0, 18'd0);
    send_sample(32'h0000_8000);
    drain();
    // shock clipping and all lags through history
    write_reg(REG_MEAN_OFFSET, 32'h8000_0000);
    write_reg(REG_POWER_EXP, 32'd0);
    write_reg(REG_ARCH_ORDER, 32'd15);
    write_reg(REG_GARCH_ORDER, 32'd0);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'h0000_0000);
    send_sample(32'h1234_5678);

    // random phases; one without gaps, one with a long receiver hold-off
    random_phase(240, 1'b1);
    random_phase(240, 1'b0);
    drain();
    gaps_on = 1'b0;
    random_phase(240, 1'b0);
    gaps_on   = 1'b1;
    stall_req = 1'b1;
    random_phase(240, 1'b0);
    random_phase(240, 1'b1);
    random_phase(230, 1'b0);

    // let the last sigma words drain
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (500) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
